### hw/rtl/bb3g_pkg.sv
// Shared types and constants of the 3x3 box blur unit.
`timescale 1ns / 1ps

package bb3g_pkg;

   localparam int PIX_BITS        = 8;
   localparam int ROW_BITS        = 12;
   localparam int COL_BITS        = 10;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int SUM_BITS        = 12;
   localparam int SLOT_COUNT      = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam int SIZE_MIN = 3;

   // floor(s / 9) == (s * 7282) >> 16 for every 9-pixel sum (s < 2304)
   localparam int RECIP_BITS  = 13;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE = 13'd7282;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

   // result slots of one input pixel, emitted in this order
   localparam int SLOT_LAG    = 0;  // pixel one row and one column behind
   localparam int SLOT_EDGE   = 1;  // right border pixel of the row above
   localparam int SLOT_BOTTOM = 2;  // input pixel itself on the last row

   typedef struct packed {
      logic [SLOT_COUNT-1:0] slot;
      logic                  interior;
      logic                  last;
      logic [SUM_BITS-1:0]   sum;
      logic [PIX_BITS-1:0]   center;
      logic [PIX_BITS-1:0]   above;
      logic [PIX_BITS-1:0]   pixel;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
   } bb3g_item_type;

endpackage

### hw/rtl/bb3g_ifs.sv
// Valid/ready channel interfaces for pixel input and blurred pixel output.
`timescale 1ns / 1ps

interface bb3g_req_if;
   logic                           valid;
   logic                           ready;
   logic [bb3g_pkg::PIX_BITS-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bb3g_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bb3g_pkg::PIX_BITS-1:0]  pixel_out;
   logic [bb3g_pkg::ROW_BITS-1:0]  out_row;
   logic [bb3g_pkg::COL_BITS-1:0]  out_col;
   logic                           frame_last;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

### hw/rtl/box_blur_3x3_gray_unit.sv
// Top level of the streaming 3x3 box blur for 8-bit grayscale frames.
`timescale 1ns / 1ps
//
//  channel  | dir | transfer when      | payload
//  ---------+-----+--------------------+----------------------------------------
//  req_if   | in  | valid && ready     | pixel_in (raster order)
//  rsp_if   | out | valid && ready     | pixel_out, out_row, out_col, frame_last
//  csr_*    | in  | csr_we             | csr_index 0 = image_width, 1 = image_height
//
// One pixel per cycle when the result side keeps up. A pixel starts its line memory
// read in the cycle it is taken and is shifted into the window when stage 1 advances;
// its results are then registered in the result stage and in the output register.
// The single result port sets the pace: a pixel at the end of a row after the first
// or on the last row past column 0 has two or three results and holds the input until all are sent.
// Synchronous active-high reset clears counters and valid flags; the line memories
// are not cleared, since no result reads a column before this frame wrote it.
// A register write restarts the frame at row 0, column 0.
//
module box_blur_3x3_gray_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   bb3g_req_if.sink                           req_if,
   bb3g_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [bb3g_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bb3g_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bb3g_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [WIDTH_REG_BITS-1:0] WIDTH_INIT =
      (MAX_WIDTH < 640) ? WIDTH_REG_BITS'(MAX_WIDTH) : WIDTH_RESET;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_INIT =
      (MAX_HEIGHT < 480) ? HEIGHT_REG_BITS'(MAX_HEIGHT) : HEIGHT_RESET;

   // frame geometry and position of the next input pixel
   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [CW-1:0]              col_ff, col_in;
   logic [RW-1:0]              row_ff, row_in;

   logic accept;
   logic last_col;
   logic last_row;
   logic emit_free;
   logic s1_adv;

   // stage 1: pixel waiting for its line memory read data
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIX_BITS-1:0]   s1_pixel_ff;
   logic [CW-1:0]         s1_addr_ff;
   logic [SLOT_COUNT-1:0] s1_slot_ff, s1_slot_in;
   logic                  s1_interior_ff, s1_interior_in;
   logic                  s1_last_ff;
   logic [ROW_BITS-1:0]   s1_row_ff, s1_row_in;
   logic [COL_BITS-1:0]   s1_col_ff, s1_col_in;
   logic [31:0]           row_wide;
   logic [31:0]           col_wide;

   // 3x3 window, index row*3 + col, row 0 oldest, col 2 newest
   logic [PIX_BITS-1:0] win_ff [9];
   logic [PIX_BITS-1:0] win_in [9];
   logic [PIX_BITS-1:0] rd_a;
   logic [PIX_BITS-1:0] rd_b;
   logic [SUM_BITS-1:0] col_sum0, col_sum1, col_sum2;
   bb3g_item_type       item;

   // -------- geometry registers and position counters --------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (32'(csr_wdata[WIDTH_REG_BITS-1:0]) < SIZE_MIN) begin
                  width_in = WIDTH_REG_BITS'(SIZE_MIN);
               end else if (32'(csr_wdata[WIDTH_REG_BITS-1:0]) > MAX_WIDTH) begin
                  width_in = WIDTH_REG_BITS'(MAX_WIDTH);
               end else begin
                  width_in = csr_wdata[WIDTH_REG_BITS-1:0];
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (32'(csr_wdata) < SIZE_MIN) begin
                  height_in = HEIGHT_REG_BITS'(SIZE_MIN);
               end else if (32'(csr_wdata) > MAX_HEIGHT) begin
                  height_in = HEIGHT_REG_BITS'(MAX_HEIGHT);
               end else begin
                  height_in = csr_wdata;
               end
            end
            default: begin
            end
         endcase
         // restart the frame on any register write
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_INIT;
         height_ff <= HEIGHT_INIT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // -------- stage 0: take the pixel, start the line memory read --------
   assign s1_adv        = s1_valid_ff && emit_free;
   assign req_if.ready  = !s1_valid_ff || emit_free;
   assign accept        = req_if.valid && req_if.ready;

   assign last_col = 32'(col_ff) == 32'(width_ff) - 32'd1;
   assign last_row = 32'(row_ff) == 32'(height_ff) - 32'd1;
   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   always_comb begin
      s1_slot_in              = '0;
      s1_slot_in[SLOT_LAG]    = (row_ff != '0) && (col_ff != '0);
      s1_slot_in[SLOT_EDGE]   = (row_ff != '0) && last_col;
      s1_slot_in[SLOT_BOTTOM] = last_row;
      s1_interior_in          = (row_wide >= 32'd2) && (col_wide >= 32'd2);
      s1_row_in               = row_wide[ROW_BITS-1:0];
      s1_col_in               = col_wide[COL_BITS-1:0];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_if.pixel_in;
         s1_addr_ff     <= col_ff;
         s1_slot_ff     <= s1_slot_in;
         s1_interior_ff <= s1_interior_in;
         s1_last_ff     <= last_col;
         s1_row_ff      <= s1_row_in;
         s1_col_ff      <= s1_col_in;
      end
   end

   // consecutive pixels always hit different columns (width >= 3), so the
   // write-back of one pixel never meets the read of the next
   bb3g_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pixel_ff)
   );

   // -------- stage 1: shift the window, add the nine pixels --------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3+0] = win_ff[i*3+1];
         win_in[i*3+1] = win_ff[i*3+2];
      end
      win_in[2] = rd_b;
      win_in[5] = rd_a;
      win_in[8] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   assign col_sum0 = SUM_BITS'(win_in[0]) + SUM_BITS'(win_in[3]) + SUM_BITS'(win_in[6]);
   assign col_sum1 = SUM_BITS'(win_in[1]) + SUM_BITS'(win_in[4]) + SUM_BITS'(win_in[7]);
   assign col_sum2 = SUM_BITS'(win_in[2]) + SUM_BITS'(win_in[5]) + SUM_BITS'(win_in[8]);

   always_comb begin
      item.slot     = s1_slot_ff;
      item.interior = s1_interior_ff;
      item.last     = s1_last_ff;
      item.sum      = col_sum0 + col_sum1 + col_sum2;
      item.center   = win_in[4];
      item.above    = win_in[5];
      item.pixel    = s1_pixel_ff;
      item.row      = s1_row_ff;
      item.col      = s1_col_ff;
   end

   // -------- stage 2 and output register --------
   bb3g_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv),
      .load_item (item),
      .free      (emit_free),
      .rsp_if    (rsp_if)
   );

endmodule

### hw/rtl/bb3g_line_store.sv
// Two line memories: row above and two rows above, read-then-shift per column.
`timescale 1ns / 1ps

module bb3g_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [bb3g_pkg::PIX_BITS-1:0] rd_a,
   output logic [bb3g_pkg::PIX_BITS-1:0] rd_b,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bb3g_pkg::PIX_BITS-1:0] wr_data
);
   import bb3g_pkg::*;

   logic [PIX_BITS-1:0] store_a_ff [DEPTH];
   logic [PIX_BITS-1:0] store_b_ff [DEPTH];
   logic [PIX_BITS-1:0] rd_a_ff;
   logic [PIX_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_a_ff[rd_addr];
         rd_b_ff <= store_b_ff[rd_addr];
      end
   end

   // old row-above value moves down, new pixel becomes row above
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a_ff[wr_addr] <= wr_data;
         store_b_ff[wr_addr] <= rd_a_ff;
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### hw/rtl/bb3g_emit.sv
// Result stage: divides interior window sums by nine and sends up to three results per pixel.
`timescale 1ns / 1ps

module bb3g_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  bb3g_pkg::bb3g_item_type load_item,
   output logic                    free,
   bb3g_rsp_if.source              rsp_if
);
   import bb3g_pkg::*;

   bb3g_item_type         item_ff, item_in;
   logic [SLOT_COUNT-1:0] slot_ff, slot_in;
   logic [SLOT_COUNT-1:0] pick;
   logic                  out_free;
   logic                  emit;
   logic [PROD_BITS-1:0]  product;
   logic [PIX_BITS-1:0]   mean;

   logic                  valid_ff, valid_in;
   logic [PIX_BITS-1:0]   pixel_ff, pixel_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic                  last_ff, last_in;

   assign product = PROD_BITS'(item_ff.sum) * PROD_BITS'(RECIP_NINE);
   assign mean    = product[RECIP_SHIFT +: PIX_BITS];

   always_comb begin
      pick = '0;
      if (slot_ff[SLOT_LAG]) begin
         pick[SLOT_LAG] = 1'b1;
      end else if (slot_ff[SLOT_EDGE]) begin
         pick[SLOT_EDGE] = 1'b1;
      end else if (slot_ff[SLOT_BOTTOM]) begin
         pick[SLOT_BOTTOM] = 1'b1;
      end
   end

   assign out_free = !valid_ff || rsp_if.ready;
   assign emit     = (slot_ff != '0) && out_free;
   assign free     = (slot_ff == '0) || (emit && ((slot_ff & ~pick) == '0));

   always_comb begin
      slot_in = slot_ff;
      item_in = item_ff;
      if (emit) begin
         slot_in = slot_ff & ~pick;
      end
      if (load && free) begin
         slot_in = load_item.slot;
         item_in = load_item;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pixel_in = pixel_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = emit;
      end
      if (emit) begin
         last_in = 1'b0;
         if (pick[SLOT_LAG]) begin
            pixel_in = item_ff.interior ? mean : item_ff.center;
            row_in   = item_ff.row - 12'd1;
            col_in   = item_ff.col - 10'd1;
         end else if (pick[SLOT_EDGE]) begin
            pixel_in = item_ff.above;
            row_in   = item_ff.row - 12'd1;
            col_in   = item_ff.col;
         end else begin
            pixel_in = item_ff.pixel;
            row_in   = item_ff.row;
            col_in   = item_ff.col;
            last_in  = item_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      pixel_ff <= pixel_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      last_ff  <= last_in;
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.pixel_out  = pixel_ff;
   assign rsp_if.out_row    = row_ff;
   assign rsp_if.out_col    = col_ff;
   assign rsp_if.frame_last = last_ff;

endmodule

### hw/rtl/bb3g_checker.sv
// Port-level checks of the box blur unit and their bind to the top level.
`timescale 1ns / 1ps

module bb3g_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bb3g_pkg::PIX_BITS-1:0] pixel_out,
   input logic [bb3g_pkg::ROW_BITS-1:0] out_row,
   input logic [bb3g_pkg::COL_BITS-1:0] out_col,
   input logic                          frame_last
);
   import bb3g_pkg::*;

   logic                rsp_xfer;
   logic [ROW_BITS-1:0] prev_row_ff, prev_row_in;
   logic [COL_BITS-1:0] prev_col_ff, prev_col_in;

   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign prev_row_in = rsp_xfer ? out_row : prev_row_ff;
   assign prev_col_in = rsp_xfer ? out_col : prev_col_ff;

   always_ff @(posedge clock) begin
      prev_row_ff <= prev_row_in;
      prev_col_ff <= prev_col_in;
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_out) && $stable(out_row)
                                  && $stable(out_col) && $stable(frame_last))
      else $error("stalled result changed");

   // after reset no result surfaces until a pixel has passed stage 1, the result stage and the output register
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result too soon after reset");

   // the frame's last pixel follows the right border pixel of the row above
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && frame_last |-> out_col == prev_col_ff)
      else $error("last pixel column does not match preceding border pixel");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && frame_last |-> out_row == prev_row_ff + 12'd1)
      else $error("last pixel row does not follow preceding border pixel");

endmodule

bind box_blur_3x3_gray_unit bb3g_checker u_bb3g_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .pixel_out  (rsp_if.pixel_out),
   .out_row    (rsp_if.out_row),
   .out_col    (rsp_if.out_col),
   .frame_last (rsp_if.frame_last)
);
